[rtl/core/ksm_pkg.sv]
`timescale 1ns / 1ps

package ksm_pkg;

  localparam int DATA_W      = 32;
  localparam int COV_W       = 32;
  localparam int COV_FRAC    = 30;
  localparam int CFG_INDEX_W = 8;
  localparam int K_W         = COV_FRAC + 1;
  localparam int DIV_STEPS   = K_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int MUL_LO_W    = 16;
  localparam int MUL_A_W     = 17;
  localparam int PROD_W      = MUL_A_W + K_W;
  localparam int ACC_W       = 63;
  localparam int STEP_W      = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = CFG_INDEX_W'(1);

  localparam logic [COV_W-1:0] PROCESS_NOISE_RESET     = 32'd10737;
  localparam logic [COV_W-1:0] MEASUREMENT_NOISE_RESET = 32'd10737418;
  localparam logic [COV_W-1:0] COV_ONE                 = 32'h4000_0000;
  localparam logic [K_W-1:0]   K_ONE                   = 31'h4000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PRED,
    OP_DEN,
    OP_DIV,
    OP_DIFF,
    OP_MUL_X_LO,
    OP_MUL_X_HI,
    OP_UPD_X,
    OP_MUL_P_LO,
    OP_MUL_P_HI,
    OP_UPD_P
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_LOOP,
    BR_WAIT_OUT,
    BR_JUMP
  } br_t;

  typedef struct packed {
    op_t               op;
    br_t               br;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic div_more;
  } dp_stat_t;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd10;

  // Microprogram: one control word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = '{op: OP_NOP, br: BR_JUMP, target: STEP_IDLE};
    case (step)
      4'd0:  uc = '{op: OP_NOP,      br: BR_WAIT_IN,  target: STEP_IDLE};
      4'd1:  uc = '{op: OP_PRED,     br: BR_NEXT,     target: STEP_IDLE};
      4'd2:  uc = '{op: OP_DEN,      br: BR_NEXT,     target: STEP_IDLE};
      4'd3:  uc = '{op: OP_DIV,      br: BR_LOOP,     target: STEP_IDLE};
      4'd4:  uc = '{op: OP_DIFF,     br: BR_NEXT,     target: STEP_IDLE};
      4'd5:  uc = '{op: OP_MUL_X_LO, br: BR_NEXT,     target: STEP_IDLE};
      4'd6:  uc = '{op: OP_MUL_X_HI, br: BR_NEXT,     target: STEP_IDLE};
      4'd7:  uc = '{op: OP_UPD_X,    br: BR_WAIT_OUT, target: STEP_IDLE};
      4'd8:  uc = '{op: OP_MUL_P_LO, br: BR_NEXT,     target: STEP_IDLE};
      4'd9:  uc = '{op: OP_MUL_P_HI, br: BR_NEXT,     target: STEP_IDLE};
      4'd10: uc = '{op: OP_UPD_P,    br: BR_JUMP,     target: STEP_IDLE};
      default: uc = '{op: OP_NOP,    br: BR_JUMP,     target: STEP_IDLE};
    endcase
    return uc;
  endfunction

endpackage

[rtl/core/ksm_in_if.sv]
`timescale 1ns / 1ps

interface ksm_in_if import ksm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[rtl/core/ksm_out_if.sv]
`timescale 1ns / 1ps

interface ksm_out_if import ksm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

[rtl/core/ksm_cfg_if.sv]
`timescale 1ns / 1ps

interface ksm_cfg_if import ksm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [COV_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/ksm_datapath.sv]
`timescale 1ns / 1ps

module ksm_datapath import ksm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  op_t                      op,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] sample,
  input  logic [COV_W-1:0]         process_noise,
  input  logic [COV_W-1:0]         measurement_noise,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] estimate_next
);

  localparam logic signed [DATA_W+2:0] NX_MAX = 35'sd2147483647;
  localparam logic signed [DATA_W+2:0] NX_MIN = -35'sd2147483648;
  localparam logic [ACC_W-1:0]         ROUND_HALF = ACC_W'(1) << (COV_FRAC - 1);

  logic signed [DATA_W-1:0] z;
  logic signed [DATA_W-1:0] x;
  logic [COV_W-1:0]         p;
  logic [COV_W-1:0]         pp;
  logic [COV_W-1:0]         den;
  logic                     zero_den;
  logic [COV_W:0]           rem;
  logic [K_W-1:0]           quot;
  logic [CNT_W-1:0]         cnt;
  logic [K_W-1:0]           k;
  logic [DATA_W:0]          mag;
  logic                     neg;
  logic [ACC_W-1:0]         acc;

  logic [COV_W:0]           pp_sum;
  logic [COV_W-1:0]         pp_sat;
  logic [COV_W:0]           den_sum;
  logic [COV_W-1:0]         den_sat;
  logic [COV_W:0]           div_sh;
  logic                     div_ge;
  logic [COV_W:0]           div_rem;
  logic [DATA_W:0]          diff;
  logic [MUL_A_W-1:0]       mul_a;
  logic [K_W-1:0]           mul_b;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         round_sum;
  logic [DATA_W:0]          q;
  logic signed [DATA_W+2:0] nx_wide;

  // Saturating predict and denominator sums.
  assign pp_sum  = {1'b0, p} + {1'b0, process_noise};
  assign pp_sat  = pp_sum[COV_W] ? '1 : pp_sum[COV_W-1:0];
  assign den_sum = {1'b0, pp} + {1'b0, measurement_noise};
  assign den_sat = den_sum[COV_W] ? '1 : den_sum[COV_W-1:0];

  // Restoring division, one quotient bit per step; the first step takes no shift.
  assign div_sh  = (cnt == CNT_W'(DIV_STEPS - 1)) ? rem : {rem[COV_W-1:0], 1'b0};
  assign div_ge  = div_sh >= {1'b0, den};
  assign div_rem = div_ge ? div_sh - {1'b0, den} : div_sh;

  assign diff = {z[DATA_W-1], z} - {x[DATA_W-1], x};

  // Shared multiplier, operands picked by the step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_X_LO: begin
        mul_a = {1'b0, mag[MUL_LO_W-1:0]};
        mul_b = k;
      end
      OP_MUL_X_HI: begin
        mul_a = mag[DATA_W:MUL_LO_W];
        mul_b = k;
      end
      OP_MUL_P_LO: begin
        mul_a = {1'b0, pp[MUL_LO_W-1:0]};
        mul_b = K_ONE - k;
      end
      OP_MUL_P_HI: begin
        mul_a = {1'b0, pp[COV_W-1:MUL_LO_W]};
        mul_b = K_ONE - k;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign round_sum = acc + ROUND_HALF;
  assign q         = round_sum[ACC_W-1:COV_FRAC];

  always_comb begin
    if (neg) begin
      nx_wide = $signed({{3{x[DATA_W-1]}}, x}) - $signed({2'b00, q});
    end else begin
      nx_wide = $signed({{3{x[DATA_W-1]}}, x}) + $signed({2'b00, q});
    end
    if (nx_wide > NX_MAX) begin
      estimate_next = NX_MAX[DATA_W-1:0];
    end else if (nx_wide < NX_MIN) begin
      estimate_next = NX_MIN[DATA_W-1:0];
    end else begin
      estimate_next = nx_wide[DATA_W-1:0];
    end
  end

  assign stat.div_more = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      x   <= '0;
      p   <= COV_ONE;
      cnt <= '0;
    end else begin
      case (op)
        OP_DEN: cnt <= CNT_W'(DIV_STEPS - 1);
        OP_DIV: begin
          if (cnt != '0) begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        OP_UPD_X: x <= estimate_next;
        OP_UPD_P: p <= round_sum[COV_FRAC+COV_W-1:COV_FRAC];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      z <= sample;
    end
    case (op)
      OP_PRED: pp <= pp_sat;
      OP_DEN: begin
        den      <= den_sat;
        zero_den <= (den_sat == '0);
        rem      <= {1'b0, pp};
        quot     <= '0;
      end
      OP_DIV: begin
        rem  <= div_rem;
        quot <= {quot[K_W-2:0], div_ge};
      end
      OP_DIFF: begin
        k   <= zero_den ? '0 : quot;
        neg <= diff[DATA_W];
        mag <= diff[DATA_W] ? -diff : diff;
      end
      OP_MUL_X_LO, OP_MUL_P_LO: acc <= ACC_W'(prod);
      OP_MUL_X_HI, OP_MUL_P_HI: acc <= acc + (ACC_W'(prod) << MUL_LO_W);
      default: begin
      end
    endcase
  end

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (op == OP_DIFF && !zero_den) |-> quot <= K_ONE)
    else $error("gain above one");

  a_zero_den_gain: assert property (@(posedge clk) disable iff (rst)
    (op == OP_DIFF && zero_den) |=> k == '0)
    else $error("gain not cleared on zero denominator");

  a_div_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

endmodule

[rtl/core/scalar_kalman_smoother.sv]
`timescale 1ns / 1ps

// One-dimensional Kalman filter for a constant state. Each sample beat on
// meas (signed Q16.16) yields exactly one beat on est carrying the updated
// estimate, in order. Q and R are written through cfg at index 0 and 1 as
// unsigned Q2.30; writes to any other index are dropped. Write them only
// while the filter is idle. After reset the estimate is 0 and the covariance
// is 1.0. A new sample is taken only in the idle step; the result is offered
// once the estimate update is registered. The 31-step restoring divider that
// forms the gain, one quotient bit per cycle, takes most of each sample's
// time; the rest are single steps of the microprogram. A finished result
// waits in the output register while the next sample is taken in; the filter
// stalls only when a second result is ready before the first one has left.
module scalar_kalman_smoother import ksm_pkg::*; (
  input logic      clk,
  input logic      rst,
  ksm_in_if.sink   meas,
  ksm_out_if.source est,
  ksm_cfg_if.sink  cfg
);

  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        step_next;
  ucode_t                   uc;
  op_t                      op_eff;
  logic                     stall;
  logic                     accept;
  dp_stat_t                 stat;
  logic signed [DATA_W-1:0] estimate_next;
  logic [COV_W-1:0]         process_noise;
  logic [COV_W-1:0]         measurement_noise;

  // Fetch the control word for the current step.
  assign uc = ucode_rom(step);

  // Hold the estimate update while the previous result still waits.
  assign stall  = (uc.br == BR_WAIT_OUT) && est.valid && !est.ready;
  assign op_eff = stall ? OP_NOP : uc.op;

  assign meas.ready = (step == STEP_IDLE);
  assign accept     = meas.valid && meas.ready;
  assign cfg.ready  = 1'b1;

  // Sequencer: advance, wait, loop or jump as the control word says.
  always_comb begin
    case (uc.br)
      BR_NEXT:     step_next = step + STEP_W'(1);
      BR_WAIT_IN:  step_next = accept ? step + STEP_W'(1) : step;
      BR_LOOP:     step_next = stat.div_more ? step : step + STEP_W'(1);
      BR_WAIT_OUT: step_next = stall ? step : step + STEP_W'(1);
      BR_JUMP:     step_next = uc.target;
      default:     step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RESET;
      measurement_noise <= MEASUREMENT_NOISE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PROCESS_NOISE:     process_noise     <= cfg.data;
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ksm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .op                (op_eff),
    .load              (accept),
    .sample            (meas.sample),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .stat              (stat),
    .estimate_next     (estimate_next)
  );

  // Output register: load on the estimate update, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      est.valid <= 1'b0;
    end else if (op_eff == OP_UPD_X) begin
      est.valid <= 1'b1;
    end else if (est.ready) begin
      est.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_eff == OP_UPD_X) begin
      est.filtered <= estimate_next;
    end
  end

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(est.valid) |-> $past(op_eff == OP_UPD_X))
    else $error("result raised outside the estimate update");

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("step counter left the program");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !meas.ready)
    else $error("sample taken while busy");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ksm_pkg::*;

  // Clamp limits of the Q16.16 estimate and the rounding constant of Q2.30.
  localparam longint X_MAX = 64'sd2147483647;
  localparam longint X_MIN = -64'sd2147483648;
  localparam longint unsigned COV_ROUND = 64'd1 << (COV_FRAC - 1);
  localparam logic [COV_W-1:0] NOISE_MAX = 32'hFFFF_FFFF;

  // Register indexes the filter must drop.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = CFG_INDEX_W'(8'hFF);

  // Cycles to let the covariance update finish after the last estimate beat.
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 75;

  // Tracks Q, R, P and x of the filter and queues the estimates it should emit.
  class kalman_scoreboard;
    logic [COV_W-1:0]         q_noise;
    logic [COV_W-1:0]         r_noise;
    logic [COV_W-1:0]         covariance;
    logic signed [DATA_W-1:0] estimate;
    logic signed [DATA_W-1:0] expected_filtered[$];
    int unsigned              failures;
    int unsigned              samples_seen;
    int unsigned              estimates_checked;
    int unsigned              reg_writes;

    function new();
      q_noise           = PROCESS_NOISE_RESET;
      r_noise           = MEASUREMENT_NOISE_RESET;
      covariance        = COV_ONE;
      estimate          = '0;
      failures          = 0;
      samples_seen      = 0;
      estimates_checked = 0;
      reg_writes        = 0;
    endfunction

    function logic [COV_W-1:0] sat_add(logic [COV_W-1:0] a, logic [COV_W-1:0] b);
      logic [COV_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COV_W] ? NOISE_MAX : s[COV_W-1:0];
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COV_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_PROCESS_NOISE:     q_noise = val;
        REG_MEASUREMENT_NOISE: r_noise = val;
        default: ;
      endcase
    endfunction

    // One filter step: advance x and P, return the new estimate.
    function logic signed [DATA_W-1:0] predict_estimate(logic signed [DATA_W-1:0] z);
      logic [COV_W-1:0] pred_cov;
      logic [COV_W-1:0] denom;
      longint unsigned  gain;
      longint unsigned  mag;
      longint unsigned  delta;
      longint           diff;
      longint           next_x;
      pred_cov = sat_add(covariance, q_noise);
      denom    = sat_add(pred_cov, r_noise);
      gain     = 0;
      // A zero denominator leaves the gain at zero: x holds, P stays zero.
      if (denom != '0) gain = (64'(pred_cov) << COV_FRAC) / 64'(denom);
      if (gain > 64'(K_ONE)) gain = 64'(K_ONE);
      diff   = longint'(z) - longint'(estimate);
      mag    = (diff < 0) ? -diff : diff;
      delta  = (mag * gain + COV_ROUND) >> COV_FRAC;
      next_x = (diff < 0) ? longint'(estimate) - longint'(delta)
                          : longint'(estimate) + longint'(delta);
      if (next_x > X_MAX) next_x = X_MAX;
      if (next_x < X_MIN) next_x = X_MIN;
      estimate   = next_x[DATA_W-1:0];
      covariance = COV_W'(((64'(K_ONE) - gain) * 64'(pred_cov) + COV_ROUND) >> COV_FRAC);
      return estimate;
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] z);
      samples_seen++;
      expected_filtered.push_back(predict_estimate(z));
    endfunction

    function void check_filtered(logic signed [DATA_W-1:0] actual);
      logic signed [DATA_W-1:0] exp_val;
      if (expected_filtered.size() == 0) begin
        $error("filtered: no estimate expected, got %0d", actual);
        failures++;
        return;
      end
      exp_val = expected_filtered.pop_front();
      estimates_checked++;
      if (actual !== exp_val) begin
        $error("filtered: expected %0d, got %0d", exp_val, actual);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;   // suppress idling on both sides while set

  ksm_in_if  meas_if ();
  ksm_out_if est_if ();
  ksm_cfg_if cfg_if ();

  kalman_scoreboard sb = new();
  int unsigned      settings_run;

  scalar_kalman_smoother u_dut (
    .clk  (clk),
    .rst  (rst),
    .meas (meas_if),
    .est  (est_if),
    .cfg  (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the filter hangs.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none or short, a few long ones; none while steady.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  // Noise variance: extremes, 1.0, or a random value spread over all scales.
  function automatic logic [COV_W-1:0] pick_noise();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return NOISE_MAX;
      2:       return COV_ONE;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Measurement: mostly noise around a level, some full-range and extremes.
  function automatic logic signed [DATA_W-1:0] pick_sample(longint level);
    int unsigned r;
    int unsigned amp;
    longint      v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 2))
        0:       amp = 32'h100;
        1:       amp = 32'h1_0000;
        default: amp = 32'h100_0000;
      endcase
      v = level + longint'($urandom_range(0, 2 * amp)) - longint'(amp);
      if (v > X_MAX) v = X_MAX;
      if (v < X_MIN) v = X_MIN;
      return v[DATA_W-1:0];
    end
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  // Observe every beat at the edge it is accepted; predict, check, track Q and R.
  always @(posedge clk) begin
    if (!rst) begin
      if (est_if.valid && est_if.ready) sb.check_filtered(est_if.filtered);
      if (meas_if.valid && meas_if.ready) sb.note_sample(meas_if.sample);
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Drive est ready: random stalls, then a run of ready.
  initial begin
    int unsigned gap;
    est_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        est_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      est_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Offer one sample beat after a random gap and hold until accepted.
  task automatic send_sample(input logic signed [DATA_W-1:0] z);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_if.valid  <= 1'b1;
    meas_if.sample <= z;
    @(posedge clk iff meas_if.ready);
  endtask

  // Hold off the sender until every pending estimate has been seen.
  task automatic drain();
    meas_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_filtered.size() != 0);
  endtask

  // Drain, then let the covariance update run out so a register write is safe.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COV_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk iff cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_noise(input logic [COV_W-1:0] q, input logic [COV_W-1:0] r);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    settings_run++;
  endtask

  // Random samples around a level; now and then pause until the filter drains.
  task automatic random_burst(input int unsigned count, input longint level);
    for (int unsigned i = 0; i < count; i++) begin
      send_sample(pick_sample(level));
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  initial begin
    longint      level;
    int unsigned waited;
    settings_run   = 1;
    rst            <= 1'b1;
    meas_if.valid  <= 1'b0;
    meas_if.sample <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset noise settings: full-scale swings across the whole Q16.16 range.
    send_sample(32'sh0000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh0000_0001);
    send_sample(32'sh0001_0000);
    send_sample(32'shFFFF_0000);
    settle();

    // Q = R = 0: first step takes the sample whole and zeroes P,
    // then the denominator is zero and the estimate must hold.
    set_noise('0, '0);
    send_sample(32'sh1234_5678);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
    settle();

    // Both sums clip at all ones.
    set_noise(NOISE_MAX, NOISE_MAX);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    settle();

    // Writes to unused indexes must be dropped.
    write_reg(REG_UNUSED_LO, '0);
    write_reg(REG_UNUSED_HI, NOISE_MAX);
    set_noise('0, NOISE_MAX);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0001_8000);
    settle();
    set_noise(NOISE_MAX, '0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'shFFFE_8000);
    settle();

    // Random phases: fresh Q and R each time, every few phases with no idling.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase % 4 == 1);
      set_noise(pick_noise(), pick_noise());
      level = longint'($signed($urandom));
      random_burst(PHASE_SAMPLES, level);
      settle();
    end
    steady = 1'b0;

    // Bounded wait for stragglers, then close out.
    meas_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.expected_filtered.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.expected_filtered.size() != 0) begin
      $error("filtered: estimate %0d never arrived", sb.expected_filtered.pop_front());
      sb.failures++;
    end

    $display("Run covered %0d samples and %0d checked estimates over %0d noise settings.",
             sb.samples_seen, sb.estimates_checked, settings_run);
    $display("Register writes: %0d, including dropped unused indexes.", sb.reg_writes);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
